FILE: hdl/mhrk_pkg.sv
// ----------------------------------------------------------------------------
// mhrk_pkg
// Shared types and constants for the replace-key min-heap.
// ----------------------------------------------------------------------------
package mhrk_pkg;

    localparam int unsigned HEAP_DEPTH_DEFAULT = 1024;

    localparam logic [1:0] OP_APPEND  = 2'd0;
    localparam logic [1:0] OP_REPLACE = 2'd1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [31:0] cost;
        logic [15:0] angle;
        logic [15:0] row;
        logic [15:0] col;
    } entry_t;

endpackage

FILE: hdl/min_heap_replace_key.sv
// ----------------------------------------------------------------------------
// min_heap_replace_key
// Binary min-heap with append, read and key replacement with sift.
// ----------------------------------------------------------------------------
// channel | dir | handshake            | payload
// s_axis  | in  | tvalid/tready        | op, position, new_cost, new_angle, row, col
// m_axis  | out | tvalid/tready        | status, final_position, cost, angle, row, col
// One transaction at a time; tready low while an op is in work.
// Append writes the key after the last entry without sift; read fetches one entry;
// then the result is registered. Replace searches entries from the last down, then
// sifts up and down (one read and one write port). Reset clears state and count only.
// Result waits in the output register until m_axis_tready.
module min_heap_replace_key
    import mhrk_pkg::*;
#(
    parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[1:0], position[12:2], new_cost[44:13], new_angle[60:45],
    // cell_row[76:61], cell_col[92:77], zero pad to 96
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], final_position[12:2], out_cost[44:13], out_angle[60:45],
    // out_row[76:61], out_col[92:77], zero pad to 96
    output logic [95:0]  m_axis_tdata
);

    localparam int unsigned AW = $clog2(HEAP_DEPTH + 1);
    localparam int unsigned PW = (AW > 11) ? AW : 11;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SRD   = 10'b0000000010,
        S_SCMP  = 10'b0000000100,
        S_URD   = 10'b0000001000,
        S_UCMP  = 10'b0000010000,
        S_DRD   = 10'b0000100000,
        S_DRD2  = 10'b0001000000,
        S_DCMP  = 10'b0010000000,
        S_RES   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] aux_reg, aux_next;
    entry_t        aux_ent_reg, aux_ent_next;
    entry_t        key_reg, key_next;
    logic          is_read_reg, is_read_next;
    logic [1:0]    status_reg, status_next;
    logic [95:0]   out_reg, out_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        wr_data, rd_data;

    logic [1:0]  in_op;
    logic [10:0] in_pos;
    logic [AW:0] c2, c2p1;

    assign in_op  = s_axis_tdata[1:0];
    assign in_pos = s_axis_tdata[12:2];
    assign c2     = {idx_reg, 1'b0};
    assign c2p1   = c2 + 1'b1;

    mhrk_store #(.HEAP_DEPTH(HEAP_DEPTH), .AW(AW)) u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = out_reg;

    always_comb
    begin
        logic [PW-1:0] pw;
        logic [PW-1:0] cw;
        pw = PW'(in_pos);
        cw = PW'(count_reg);
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        aux_next     = aux_reg;
        aux_ent_next = aux_ent_reg;
        key_next     = key_reg;
        is_read_next = is_read_reg;
        status_next  = status_reg;
        out_next     = out_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = key_reg;
        rd_addr      = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    key_next.cost  = s_axis_tdata[44:13];
                    key_next.angle = s_axis_tdata[60:45];
                    key_next.row   = s_axis_tdata[76:61];
                    key_next.col   = s_axis_tdata[92:77];
                    status_next    = ST_OK;
                    is_read_next   = 1'b0;
                    if (in_op[1])
                    begin
                        idx_next     = AW'(in_pos);
                        is_read_next = 1'b1;
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_RES;
                        end
                        else if (in_pos == '0 || pw > cw)
                        begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_RES;
                        end
                        else
                        begin
                            state_next = S_SRD;
                        end
                    end
                    else if (in_op == OP_APPEND)
                    begin
                        if (32'(count_reg) >= 32'(HEAP_DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_RES;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            idx_next   = count_reg + 1'b1;
                            state_next = S_DCMP;
                            aux_next   = '0;
                        end
                    end
                    else
                    begin
                        idx_next = count_reg;
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_RES;
                        end
                        else
                        begin
                            state_next = S_SRD;
                        end
                    end
                end
            end
            S_SRD:
            begin
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (is_read_reg)
                begin
                    key_next   = rd_data;
                    state_next = S_RES;
                end
                else if (rd_data.row == key_reg.row && rd_data.col == key_reg.col)
                begin
                    state_next = S_URD;
                end
                else if (idx_reg == AW'(1))
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RES;
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_SRD;
                end
            end
            S_URD:
            begin
                rd_addr = idx_reg >> 1;
                if (idx_reg > AW'(1))
                begin
                    state_next = S_UCMP;
                end
                else
                begin
                    state_next = S_DRD;
                end
            end
            S_UCMP:
            begin
                if (key_reg.cost < rd_data.cost)
                begin
                    wr_en      = 1'b1;
                    wr_data    = rd_data;
                    idx_next   = idx_reg >> 1;
                    state_next = S_URD;
                end
                else
                begin
                    state_next = S_DRD;
                end
            end
            S_DRD:
            begin
                rd_addr = c2[AW-1:0];
                if (c2 <= {1'b0, count_reg})
                begin
                    state_next = S_DRD2;
                end
                else
                begin
                    aux_next   = '0;
                    state_next = S_DCMP;
                end
            end
            S_DRD2:
            begin
                rd_addr      = c2p1[AW-1:0];
                aux_ent_next = rd_data;
                aux_next     = c2[AW-1:0];
                if (c2 < {1'b0, count_reg})
                begin
                    state_next = S_DCMP;
                end
                else
                begin
                    state_next = S_DCMP;
                    idx_next   = idx_reg;
                end
            end
            S_DCMP:
            begin
                // aux_reg == 0: no child, place key
                begin
                    logic          use_right;
                    entry_t        ch;
                    logic [AW-1:0] ci;
                    use_right = (aux_reg != '0) && (c2 < {1'b0, count_reg})
                                && (aux_ent_reg.cost > rd_data.cost);
                    ch = use_right ? rd_data : aux_ent_reg;
                    ci = use_right ? c2p1[AW-1:0] : aux_reg;
                    if (aux_reg != '0 && key_reg.cost > ch.cost)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = ch;
                        idx_next   = ci;
                        state_next = S_DRD;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_data    = key_reg;
                        state_next = S_RES;
                    end
                end
            end
            S_RES:
            begin
                if (status_reg != ST_OK)
                begin
                    out_next = {94'd0, status_reg};
                end
                else
                begin
                    out_next = {3'd0, key_reg.col, key_reg.row, key_reg.angle,
                                key_reg.cost, 11'(idx_reg), status_reg};
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        aux_reg     <= aux_next;
        aux_ent_reg <= aux_ent_next;
        key_reg     <= key_next;
        is_read_reg <= is_read_next;
        status_reg  <= status_next;
        out_reg     <= out_next;
    end

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(HEAP_DEPTH))
        else $error("entry count beyond depth");

    a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_OUT) |-> !wr_en)
        else $error("heap write outside an operation");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(out_reg))
        else $error("result changed while stalled");

endmodule

FILE: hdl/mhrk_store.sv
// ----------------------------------------------------------------------------
// mhrk_store
// Heap entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mhrk_store
    import mhrk_pkg::*;
#(
    parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEFAULT,
    parameter int unsigned AW = $clog2(HEAP_DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [0:HEAP_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
